// ===== hdl/lgrs_pkg.sv =====
// Shared types and constants of the row-streamed Life generation block.
package lgrs_pkg;

	localparam int ROW_BITS   = 64;
	localparam int MAX_ROWS   = 4096;
	localparam int ROW_IDX_W  = $clog2(MAX_ROWS);
	localparam int ROWS_CFG_W = 13;
	localparam int COLS_CFG_W = 7;
	localparam int COL_SEL_W  = $clog2(ROW_BITS);
	localparam int MIN_DIM    = 3;

	// Register indexes on the configuration port.
	localparam logic REG_ROWS_IN_USE = 1'b0;
	localparam logic REG_COLS_IN_USE = 1'b1;

	// Sequencer phase; it also selects the row window that the cells look at.
	typedef enum logic [1:0] {
		PH_ROW,
		PH_TAIL1,
		PH_TAIL2
	} phase_t;

	// Bits of one column: row above, the row itself, row below.
	typedef struct packed {
		logic up;
		logic mid;
		logic down;
	} col_t;

	typedef struct packed {
		logic   ld_first;
		logic   ld_second;
		logic   shift;
		phase_t win;
	} cell_ctrl_t;

	typedef struct packed {
		logic                 frame_done;
		logic [ROW_BITS-1:0]  next_cells;
		logic [ROW_IDX_W-1:0] row_index;
	} result_t;

endpackage

// ===== hdl/life_generation_row_stream.sv =====
// Top level of the row-streamed toroidal Life generation block.
//
// Rows of one frame enter on the s_ channel, one 64-bit row per item, in order 0 to H-1,
// where H is rows_in_use clamped to 3..4096; columns wrap at cols_in_use clamped to 3..64.
// Results leave on the m_ channel: next-generation row index and cells in m_tdata, with
// m_tlast marking the last result of a frame, which is always row 0.
// Rows 0 and 1 give no result. Row r gives row r-1, which is pushed into the result buffer
// as row r is accepted. The last row of a frame gives rows H-2, H-1 and 0 in that order.
// Throughput is one row per cycle while the result buffer has space, except that the last row
// of a frame needs two more passes of the cell row over its stored rows; s_tready is low during them.
// Every column is a cell that stores its bit of the first two rows and of the two latest
// rows; each cycle it hands its window bits to both neighbors and forms its next state.
// A two-entry result buffer sits before the m_ side. When the receiver stalls the buffer
// fills and s_tready drops, so no result is lost; s_tready depends on registers only.
// Reset sets rows_in_use to 4096 and cols_in_use to 64, clears the stored rows and the buffer,
// and starts a new frame at row 0. The user must write registers over APB while idle; the block does not check.
module life_generation_row_stream (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Row input: s_tdata holds row_cells [63:0].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,
	// Result output: m_tdata holds row_index [11:0], next_cells [75:12], zero [79:76].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,
	output logic        m_tlast
);
	import lgrs_pkg::*;

	logic [ROWS_CFG_W-1:0] rows_in_use_q;
	logic [COLS_CFG_W-1:0] cols_in_use_q;
	logic [ROWS_CFG_W-1:0] eff_rows;
	logic [COLS_CFG_W-1:0] eff_cols;
	logic [ROWS_CFG_W-1:0] rows_m1_w, rows_m2_w;
	logic [ROW_IDX_W-1:0]  rows_m1, rows_m2;

	phase_t               phase_q, phase_d;
	logic [ROW_IDX_W-1:0] rows_received_q, rows_received_d;

	logic       cfg_wr;
	logic       s_accept;
	logic       is_last;
	logic       space;
	logic       res_push;
	result_t    res_item;
	result_t    out_item;
	cell_ctrl_t ctrl;
	logic [ROW_BITS-1:0] next_row;

	// Configuration registers. Bit 2 of the address picks the register.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= ROWS_CFG_W'(MAX_ROWS);
			cols_in_use_q <= COLS_CFG_W'(ROW_BITS);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ROWS_IN_USE: rows_in_use_q <= pwdata[ROWS_CFG_W-1:0];
				REG_COLS_IN_USE: cols_in_use_q <= pwdata[COLS_CFG_W-1:0];
				default:         rows_in_use_q <= rows_in_use_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ROWS_IN_USE: prdata = {{(32-ROWS_CFG_W){1'b0}}, rows_in_use_q};
			REG_COLS_IN_USE: prdata = {{(32-COLS_CFG_W){1'b0}}, cols_in_use_q};
			default:         prdata = '0;
		endcase
	end

	// Out-of-range counts are clamped to the supported grid.
	always_comb begin
		priority if (rows_in_use_q < ROWS_CFG_W'(MIN_DIM)) eff_rows = ROWS_CFG_W'(MIN_DIM);
		else if (rows_in_use_q > ROWS_CFG_W'(MAX_ROWS))   eff_rows = ROWS_CFG_W'(MAX_ROWS);
		else                                               eff_rows = rows_in_use_q;
	end

	always_comb begin
		priority if (cols_in_use_q < COLS_CFG_W'(MIN_DIM)) eff_cols = COLS_CFG_W'(MIN_DIM);
		else if (cols_in_use_q > COLS_CFG_W'(ROW_BITS))   eff_cols = COLS_CFG_W'(ROW_BITS);
		else                                               eff_cols = cols_in_use_q;
	end

	assign rows_m1_w = eff_rows - ROWS_CFG_W'(1);
	assign rows_m2_w = eff_rows - ROWS_CFG_W'(2);
	assign rows_m1   = rows_m1_w[ROW_IDX_W-1:0];
	assign rows_m2   = rows_m2_w[ROW_IDX_W-1:0];

	// A row at or past H-1 closes the frame, also when H was lowered mid-frame.
	assign is_last  = (rows_received_q >= ROW_IDX_W'(2)) && (rows_received_q >= rows_m1);
	assign s_accept = s_tvalid & s_tready;

	// Next state of the sequencer.
	always_comb begin
		phase_d         = phase_q;
		rows_received_d = rows_received_q;
		unique case (phase_q)
			PH_ROW: begin
				if (s_accept) begin
					if (is_last) begin
						phase_d         = PH_TAIL1;
						rows_received_d = '0;
					end else begin
						rows_received_d = rows_received_q + ROW_IDX_W'(1);
					end
				end
			end
			PH_TAIL1: begin
				if (space) phase_d = PH_TAIL2;
			end
			PH_TAIL2: begin
				if (space) phase_d = PH_ROW;
			end
			default: phase_d = PH_ROW;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_ROW;
			rows_received_q <= '0;
		end else begin
			phase_q         <= phase_d;
			rows_received_q <= rows_received_d;
		end
	end

	// Sequencer outputs: cell controls, handshake and the result to buffer.
	always_comb begin
		s_tready            = 1'b0;
		res_push            = 1'b0;
		ctrl                = '{ld_first: 1'b0, ld_second: 1'b0, shift: 1'b0, win: PH_ROW};
		res_item.row_index  = rows_received_q - ROW_IDX_W'(1);
		res_item.frame_done = 1'b0;
		unique case (phase_q)
			PH_ROW: begin
				s_tready       = space;
				ctrl.ld_first  = s_accept && (rows_received_q == ROW_IDX_W'(0));
				ctrl.ld_second = s_accept && (rows_received_q == ROW_IDX_W'(1));
				ctrl.shift     = s_accept;
				res_push       = s_accept && (rows_received_q >= ROW_IDX_W'(2));
				if (is_last) res_item.row_index = rows_m2;
			end
			PH_TAIL1: begin
				ctrl.win           = PH_TAIL1;
				res_push           = space;
				res_item.row_index = rows_m1;
			end
			PH_TAIL2: begin
				ctrl.win            = PH_TAIL2;
				res_push            = space;
				res_item.row_index  = '0;
				res_item.frame_done = 1'b1;
			end
			default: res_push = 1'b0;
		endcase
		res_item.next_cells = next_row;
	end

	lgrs_cell_row u_cell_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.cols     (eff_cols),
		.cur_row  (s_tdata),
		.next_row (next_row)
	);

	lgrs_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_item (res_item),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	assign m_tdata = {4'b0, out_item.next_cells, out_item.row_index};
	assign m_tlast = out_item.frame_done;

	// The closing row restarts the row count before the two tail passes.
	a_tail_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TAIL1 || phase_q == PH_TAIL2) |-> (rows_received_q == '0))
		else $error("row count not cleared during the frame tail");

	// Only the final tail pass may mark the end of a frame.
	a_done_from_tail2: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_item.frame_done) |-> (phase_q == PH_TAIL2))
		else $error("frame end marked outside the final tail pass");

	// The last result of a frame is always row 0.
	a_last_is_row0: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[ROW_IDX_W-1:0] == '0))
		else $error("frame end carried on a row other than 0");

endmodule

// ===== hdl/lgrs_cell.sv =====
// One column cell: holds its column's bits of the stored rows and computes its next state.
module lgrs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  lgrs_pkg::cell_ctrl_t ctrl,
	input  logic               active,
	input  logic               cur_bit,
	input  lgrs_pkg::col_t     left,
	input  lgrs_pkg::col_t     right,
	output lgrs_pkg::col_t     own,
	output logic               next_bit
);
	import lgrs_pkg::*;

	logic first_q, second_q, older_q, newer_q;
	logic cur_m;
	col_t raw;
	logic [3:0] n;

	assign cur_m = cur_bit & active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= 1'b0;
			second_q <= 1'b0;
			older_q  <= 1'b0;
			newer_q  <= 1'b0;
		end else begin
			if (ctrl.ld_first) first_q <= cur_m;
			if (ctrl.ld_second) second_q <= cur_m;
			if (ctrl.shift) begin
				older_q <= newer_q;
				newer_q <= cur_m;
			end
		end
	end

	always_comb begin
		unique case (ctrl.win)
			PH_ROW:   raw = '{up: older_q, mid: newer_q, down: cur_m};
			PH_TAIL1: raw = '{up: older_q, mid: newer_q, down: first_q};
			PH_TAIL2: raw = '{up: newer_q, mid: first_q, down: second_q};
			default:  raw = '0;
		endcase
	end

	// Columns past the wrap point read as dead.
	assign own = active ? raw : '0;

	assign n = {3'b0, left.up} + {3'b0, left.mid} + {3'b0, left.down}
		+ {3'b0, own.up} + {3'b0, own.down}
		+ {3'b0, right.up} + {3'b0, right.mid} + {3'b0, right.down};

	assign next_bit = active & ((n == 4'd3) | (own.mid & (n == 4'd2)));

endmodule

// ===== hdl/lgrs_cell_row.sv =====
// Row of column cells with toroidal neighbor wiring at the active column count.
module lgrs_cell_row (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lgrs_pkg::cell_ctrl_t                ctrl,
	input  logic [lgrs_pkg::COLS_CFG_W-1:0]     cols,
	input  logic [lgrs_pkg::ROW_BITS-1:0]       cur_row,
	output logic [lgrs_pkg::ROW_BITS-1:0]       next_row
);
	import lgrs_pkg::*;

	col_t                  col_w [ROW_BITS];
	logic [COLS_CFG_W-1:0] cols_m1;
	logic [COL_SEL_W-1:0]  last_col;

	assign cols_m1  = cols - COLS_CFG_W'(1);
	assign last_col = cols_m1[COL_SEL_W-1:0];

	for (genvar c = 0; c < ROW_BITS; c++) begin : g_cell
		col_t left, right;
		logic active;

		assign active = (COLS_CFG_W'(c) < cols);

		if (c == 0) begin : g_left_wrap
			assign left = col_w[last_col];
		end else begin : g_left
			assign left = col_w[c-1];
		end

		if (c == ROW_BITS-1) begin : g_right_wrap
			assign right = col_w[0];
		end else begin : g_right
			assign right = (COL_SEL_W'(c) == last_col) ? col_w[0] : col_w[c+1];
		end

		lgrs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.active   (active),
			.cur_bit  (cur_row[c]),
			.left     (left),
			.right    (right),
			.own      (col_w[c]),
			.next_bit (next_row[c])
		);
	end

endmodule

// ===== hdl/lgrs_out_fifo.sv =====
// Two-entry result buffer that parts the input side from the output side.
module lgrs_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lgrs_pkg::result_t push_item,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output lgrs_pkg::result_t out_item
);
	import lgrs_pkg::*;

	result_t    mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign space     = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_item  = mem_q[rd_ptr_q];
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
